[src/image_dihedral_reorganizer_unit_macros.svh]
// Assertion macros of the checker file of the image dihedral reorganizer.
// No dependencies; included by the checker that is bound to the top level.
`ifndef IMAGE_DIHEDRAL_REORGANIZER_UNIT_MACROS_SVH
`define IMAGE_DIHEDRAL_REORGANIZER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DIHR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// Next-cycle implication, disabled while reset is asserted.
`define DIHR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

[src/dihr_pkg.sv]
// Package of the image dihedral reorganizer: payload and register types, codes.
// No dependencies; imported by every module of the block but dihr_ram.
package dihr_pkg;

    // Transform codes of the transform register.
    localparam logic [2:0] TR_IDENTITY  = 3'd0;
    localparam logic [2:0] TR_HFLIP     = 3'd1;
    localparam logic [2:0] TR_VFLIP     = 3'd2;
    localparam logic [2:0] TR_TRANSPOSE = 3'd3;
    localparam logic [2:0] TR_ROT90     = 3'd4;
    localparam logic [2:0] TR_ROT180    = 3'd5;
    localparam logic [2:0] TR_ROT270    = 3'd6;
    localparam logic [2:0] TR_ANTITRANS = 3'd7;

    // Configuration register indexes.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANSFORM = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IN_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IN_HEIGHT = 2'd2;

    // Reset values of the size registers.
    localparam logic [8:0] IN_WIDTH_RESET  = 9'd256;
    localparam logic [8:0] IN_HEIGHT_RESET = 9'd256;

    // Item modes.
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_FETCH = 1'b1;

    typedef struct packed {
        logic       mode;
        logic [7:0] pixel_in;
    } in_item_t;

    typedef struct packed {
        logic [7:0] pixel_out;
        logic [7:0] out_col;
        logic [7:0] out_row;
        logic       last;
        logic       status;
    } out_item_t;

    typedef struct packed {
        logic [2:0] transform;
        logic [8:0] in_width;
        logic [8:0] in_height;
    } cfg_regs_t;

    // Position and status of a fetch, carried alongside the frame store read.
    typedef struct packed {
        logic [7:0] col;
        logic [7:0] row;
        logic       last;
        logic       status;
    } fetch_meta_t;

endpackage

[src/image_dihedral_reorganizer_unit.sv]
// Image dihedral reorganizer. Load transfers write 8-bit pixels in input raster
// order into a frame store of MAX_WIDTH x MAX_HEIGHT bytes (row stride MAX_WIDTH);
// fetch transfers return the image in output raster order under the selected
// rotation or mirror, with a status of 1 and zero fields while no full frame is
// loaded. One item is taken every clock cycle while results are taken; a held
// result with a fetch waiting behind it stops the input. A fetch result passes
// through the registered read of the frame store and then the output register.
// The store is not cleared after reset and is ready at once. Registers may be
// written only while the block is idle; a write to any of the three registers
// restarts loading.
// Depends on dihr_pkg, dihr_ctrl and dihr_ram.
module image_dihedral_reorganizer_unit
    import dihr_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    logic        run_reg;
    cfg_regs_t   cfg_reg, cfg_next;
    logic        restart;
    logic        cfg_xfer;

    logic        accept, step_load, step_fetch;
    logic        ram_we, ram_re;
    logic [AW-1:0] ram_addr;
    logic [7:0]  ram_rdata;
    fetch_meta_t meta;

    logic        s1_valid_reg, s1_valid_next;
    fetch_meta_t s1_meta_reg;
    logic        s1_move;
    logic        m_valid_reg, m_valid_next;
    out_item_t   m_data_reg;

    // Ports open in the cycle after reset is released.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 1'b0;
        end else begin
            run_reg <= 1'b1;
        end
    end

    // Configuration registers; a write to a known register restarts the frame.
    assign cfg_ready = run_reg;
    assign cfg_xfer  = cfg_valid & cfg_ready;

    always_comb begin
        cfg_next = cfg_reg;
        restart  = 1'b0;
        if (cfg_xfer) begin
            case (cfg_index)
                CFG_TRANSFORM: begin
                    cfg_next.transform = cfg_data[2:0];
                    restart            = 1'b1;
                end
                CFG_IN_WIDTH: begin
                    cfg_next.in_width = cfg_data;
                    restart           = 1'b1;
                end
                CFG_IN_HEIGHT: begin
                    cfg_next.in_height = cfg_data;
                    restart            = 1'b1;
                end
                default: begin
                    restart = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.transform <= TR_IDENTITY;
            cfg_reg.in_width  <= IN_WIDTH_RESET;
            cfg_reg.in_height <= IN_HEIGHT_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Input transfer: taken whenever the read stage can hand on its result.
    assign s_ready    = run_reg & (~s1_valid_reg | ~m_valid_reg | m_ready);
    assign accept     = s_valid & s_ready;
    assign step_load  = accept & (s_data.mode == MODE_LOAD);
    assign step_fetch = accept & (s_data.mode == MODE_FETCH);

    dihr_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_load  (step_load),
        .step_fetch (step_fetch),
        .restart    (restart),
        .cfg        (cfg_reg),
        .ram_we     (ram_we),
        .ram_re     (ram_re),
        .ram_addr   (ram_addr),
        .meta       (meta)
    );

    dihr_ram #(
        .DATA_W (8),
        .DEPTH  (DEPTH)
    ) u_frame_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_addr),
        .wdata (s_data.pixel_in),
        .re    (ram_re),
        .raddr (ram_addr),
        .rdata (ram_rdata)
    );

    // Read stage: fetch metadata waits here while the store read completes.
    assign s1_move = s1_valid_reg & (~m_valid_reg | m_ready);

    always_comb begin
        if (step_fetch) begin
            s1_valid_next = 1'b1;
        end else if (s1_move) begin
            s1_valid_next = 1'b0;
        end else begin
            s1_valid_next = s1_valid_reg;
        end
        if (s1_move) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers of the read stage and the result.
    always_ff @(posedge aclk) begin
        if (step_fetch) begin
            s1_meta_reg <= meta;
        end
        if (s1_move) begin
            m_data_reg.pixel_out <= s1_meta_reg.status ? 8'd0 : ram_rdata;
            m_data_reg.out_col   <= s1_meta_reg.col;
            m_data_reg.out_row   <= s1_meta_reg.row;
            m_data_reg.last      <= s1_meta_reg.last;
            m_data_reg.status    <= s1_meta_reg.status;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[src/dihr_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; used for the frame store.
module dihr_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 65536
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; holds its data until the next read.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/dihr_ctrl.sv]
// Load and fetch position counters and frame store address generation.
// Depends on dihr_pkg for the register, metadata and transform definitions.
module dihr_ctrl
    import dihr_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  step_load,
    input  logic                                  step_fetch,
    input  logic                                  restart,
    input  cfg_regs_t                             cfg,
    output logic                                  ram_we,
    output logic                                  ram_re,
    output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0] ram_addr,
    output fetch_meta_t                           meta
);

    localparam int CNT_W = $clog2((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT);
    localparam int SW    = CNT_W + 10;
    localparam int XW    = CNT_W + 8;
    localparam int AW    = $clog2(MAX_WIDTH * MAX_HEIGHT);

    logic [CNT_W-1:0] load_col_reg, load_col_next;
    logic [CNT_W-1:0] load_row_reg, load_row_next;
    logic [CNT_W-1:0] emit_col_reg, emit_col_next;
    logic [CNT_W-1:0] emit_row_reg, emit_row_next;
    logic             frame_ready_reg, frame_ready_next;

    logic [SW-1:0]    in_w, in_h, w, h, ow, oh;
    logic             swap;
    logic [CNT_W-1:0] lc, lr, ec, er;
    logic [SW-1:0]    src_row_x, src_col_x;
    logic [CNT_W-1:0] src_row, src_col;
    logic [AW-1:0]    load_addr, fetch_addr;
    logic [XW-1:0]    ec_x, er_x;
    logic             load_start, load_col_more, load_row_more;
    logic             emit_col_more, emit_row_more;

    // Effective sizes: saturate to one and to the store dimensions.
    always_comb begin
        in_w = SW'(cfg.in_width);
        in_h = SW'(cfg.in_height);
        if (in_w == '0) begin
            w = SW'(1);
        end else if (in_w > SW'(MAX_WIDTH)) begin
            w = SW'(MAX_WIDTH);
        end else begin
            w = in_w;
        end
        if (in_h == '0) begin
            h = SW'(1);
        end else if (in_h > SW'(MAX_HEIGHT)) begin
            h = SW'(MAX_HEIGHT);
        end else begin
            h = in_h;
        end
        swap = (cfg.transform == TR_TRANSPOSE) || (cfg.transform == TR_ROT90) ||
               (cfg.transform == TR_ROT270) || (cfg.transform == TR_ANTITRANS);
        ow = swap ? h : w;
        oh = swap ? w : h;
    end

    // Current positions, restarted when they fall outside the frame.
    always_comb begin
        if (SW'(load_col_reg) >= w || SW'(load_row_reg) >= h) begin
            lc = '0;
            lr = '0;
        end else begin
            lc = load_col_reg;
            lr = load_row_reg;
        end
        if (SW'(emit_col_reg) >= ow || SW'(emit_row_reg) >= oh) begin
            ec = '0;
            er = '0;
        end else begin
            ec = emit_col_reg;
            er = emit_row_reg;
        end
    end

    // Source pixel of the current output position.
    always_comb begin
        case (cfg.transform)
            TR_IDENTITY: begin
                src_row_x = SW'(er);
                src_col_x = SW'(ec);
            end
            TR_HFLIP: begin
                src_row_x = SW'(er);
                src_col_x = w - SW'(1) - SW'(ec);
            end
            TR_VFLIP: begin
                src_row_x = h - SW'(1) - SW'(er);
                src_col_x = SW'(ec);
            end
            TR_TRANSPOSE: begin
                src_row_x = SW'(ec);
                src_col_x = SW'(er);
            end
            TR_ROT90: begin
                src_row_x = SW'(ec);
                src_col_x = w - SW'(1) - SW'(er);
            end
            TR_ROT180: begin
                src_row_x = h - SW'(1) - SW'(er);
                src_col_x = w - SW'(1) - SW'(ec);
            end
            TR_ROT270: begin
                src_row_x = h - SW'(1) - SW'(ec);
                src_col_x = SW'(er);
            end
            default: begin
                src_row_x = h - SW'(1) - SW'(ec);
                src_col_x = w - SW'(1) - SW'(er);
            end
        endcase
        src_row = src_row_x[CNT_W-1:0];
        src_col = src_col_x[CNT_W-1:0];
    end

    // Store addresses with a fixed row stride.
    assign load_addr  = AW'(lr) * AW'(MAX_WIDTH) + AW'(lc);
    assign fetch_addr = AW'(src_row) * AW'(MAX_WIDTH) + AW'(src_col);

    assign ram_we   = step_load;
    assign ram_re   = step_fetch & frame_ready_reg;
    assign ram_addr = step_load ? load_addr : fetch_addr;

    // Output position and status of a fetch.
    assign load_start    = (lc == '0) && (lr == '0);
    assign load_col_more = (SW'(lc) + SW'(1)) < w;
    assign load_row_more = (SW'(lr) + SW'(1)) < h;
    assign emit_col_more = (SW'(ec) + SW'(1)) < ow;
    assign emit_row_more = (SW'(er) + SW'(1)) < oh;
    assign ec_x = XW'(ec);
    assign er_x = XW'(er);

    always_comb begin
        if (frame_ready_reg) begin
            meta.col    = ec_x[7:0];
            meta.row    = er_x[7:0];
            meta.last   = ((SW'(ec) + SW'(1)) == ow) && ((SW'(er) + SW'(1)) == oh);
            meta.status = 1'b0;
        end else begin
            meta.col    = '0;
            meta.row    = '0;
            meta.last   = 1'b0;
            meta.status = 1'b1;
        end
    end

    // Counter updates.
    always_comb begin
        load_col_next    = load_col_reg;
        load_row_next    = load_row_reg;
        emit_col_next    = emit_col_reg;
        emit_row_next    = emit_row_reg;
        frame_ready_next = frame_ready_reg;
        if (restart) begin
            load_col_next    = '0;
            load_row_next    = '0;
            emit_col_next    = '0;
            emit_row_next    = '0;
            frame_ready_next = 1'b0;
        end else if (step_load) begin
            if (load_start) begin
                frame_ready_next = 1'b0;
                emit_col_next    = '0;
                emit_row_next    = '0;
            end
            if (load_col_more) begin
                load_col_next = lc + CNT_W'(1);
                load_row_next = lr;
            end else begin
                load_col_next = '0;
                if (load_row_more) begin
                    load_row_next = lr + CNT_W'(1);
                end else begin
                    load_row_next    = '0;
                    frame_ready_next = 1'b1;
                end
            end
        end else if (step_fetch && frame_ready_reg) begin
            if (emit_col_more) begin
                emit_col_next = ec + CNT_W'(1);
                emit_row_next = er;
            end else begin
                emit_col_next = '0;
                emit_row_next = emit_row_more ? (er + CNT_W'(1)) : '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_col_reg    <= '0;
            load_row_reg    <= '0;
            emit_col_reg    <= '0;
            emit_row_reg    <= '0;
            frame_ready_reg <= 1'b0;
        end else begin
            load_col_reg    <= load_col_next;
            load_row_reg    <= load_row_next;
            emit_col_reg    <= emit_col_next;
            emit_row_reg    <= emit_row_next;
            frame_ready_reg <= frame_ready_next;
        end
    end

endmodule

[src/dihr_checker.sv]
// Port-level checker of the image dihedral reorganizer, bound to the top level.
// Depends on dihr_pkg and the assertion macros header.
`include "image_dihedral_reorganizer_unit_macros.svh"

module dihr_checker
    import dihr_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input in_item_t              s_data,
    input logic                  m_valid,
    input logic                  m_ready,
    input out_item_t             m_data
);

    logic fetch_xfer;

    assign fetch_xfer = s_valid && s_ready && (s_data.mode == MODE_FETCH);

    // A stalled result holds.
    `DIHR_ASSERT_NEXT(a_result_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))
    // An error result carries no pixel, position or end of frame.
    `DIHR_ASSERT_IMPL(a_error_zero, aclk, aresetn, m_valid && m_data.status, (m_data.pixel_out == 8'd0) && (m_data.out_col == 8'd0) && (m_data.out_row == 8'd0) && !m_data.last)
    // A result that starts a burst comes from a fetch transfer through the read stage.
    `DIHR_ASSERT_IMPL(a_result_source, aclk, aresetn, $rose(m_valid), $past(fetch_xfer, 2))
    // An end-of-frame flag never comes with an error status.
    `DIHR_ASSERT_IMPL(a_last_ok, aclk, aresetn, m_valid && m_data.last, !m_data.status)

endmodule

bind image_dihedral_reorganizer_unit dihr_checker u_dihr_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_data    (s_data),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_data    (m_data)
);

[sim/image_dihedral_reorganizer_unit_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the image dihedral reorganizer: a frame store model
// predicts every fetch result, which is checked field by field against the block.
// Depends on dihr_pkg and image_dihedral_reorganizer_unit.
module image_dihedral_reorganizer_unit_tb;
    import dihr_pkg::*;

    localparam int MAX_W = 256;
    localparam int MAX_H = 256;
    // The port carries two index bits; the last index names no register.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 200;
    // Pause before a register write so that the block is quiet.
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES = 10;
    // Idle gaps are geometric with a 24% chance per cycle, so a stall counter that
    // reaches STALL_LIMIT can only mean a hung block.
    localparam int STALL_LIMIT = 2000;

    logic            aclk;
    logic            aresetn;
    logic            s_valid;
    logic            s_ready;
    in_item_t        s_data;
    logic            m_valid;
    logic            m_ready = 1'b0;
    out_item_t       m_data;
    logic            cfg_valid;
    logic            cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Predictor state: a copy of the store, the positions and the registers.
    logic [7:0]  pixel_store [MAX_W*MAX_H];
    int          load_col, load_row, emit_col, emit_row;
    bit          frame_loaded;
    logic [2:0]  cfg_transform;
    logic [8:0]  cfg_width, cfg_height;

    out_item_t   expected_pixels [$];
    out_item_t   want_item;
    int          mismatch_count = 0;
    int          items_sent;
    bit          no_idle;
    int unsigned stall_cycles = 0;

    image_dihedral_reorganizer_unit #(
        .MAX_WIDTH (MAX_W),
        .MAX_HEIGHT(MAX_H)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Sizes act as saturated to 1..limit.
    function automatic int clamp_dim(logic [8:0] v, int limit);
        if (v == 0) return 1;
        if (v > limit) return limit;
        return int'(v);
    endfunction

    function automatic int frame_pixels();
        return clamp_dim(cfg_width, MAX_W) * clamp_dim(cfg_height, MAX_H);
    endfunction

    function automatic void restart_positions();
        load_col = 0;
        load_row = 0;
        emit_col = 0;
        emit_row = 0;
        frame_loaded = 1'b0;
    endfunction

    // Applies one accepted item to the frame store copy and queues the fetch result.
    task automatic predict_item(input in_item_t item);
        int w, h, ow, oh, src_row, src_col;
        bit swap;
        out_item_t res;
        w = clamp_dim(cfg_width, MAX_W);
        h = clamp_dim(cfg_height, MAX_H);
        swap = (cfg_transform == TR_TRANSPOSE) || (cfg_transform == TR_ROT90) ||
               (cfg_transform == TR_ROT270) || (cfg_transform == TR_ANTITRANS);
        ow = swap ? h : w;
        oh = swap ? w : h;
        res = '0;
        if (item.mode == MODE_LOAD) begin
            if (load_col >= w || load_row >= h) begin
                load_col = 0;
                load_row = 0;
            end
            // A load at the origin starts a new frame.
            if (load_col == 0 && load_row == 0) begin
                frame_loaded = 1'b0;
                emit_col = 0;
                emit_row = 0;
            end
            pixel_store[load_row * MAX_W + load_col] = item.pixel_in;
            if (load_col + 1 < w) begin
                load_col++;
            end else begin
                load_col = 0;
                if (load_row + 1 < h) begin
                    load_row++;
                end else begin
                    load_row = 0;
                    frame_loaded = 1'b1;
                end
            end
            return;
        end
        if (!frame_loaded) begin
            res.status = 1'b1;
            expected_pixels.push_back(res);
            return;
        end
        if (emit_col >= ow || emit_row >= oh) begin
            emit_col = 0;
            emit_row = 0;
        end
        // Map the output position back to its source pixel.
        case (cfg_transform)
            TR_IDENTITY: begin src_row = emit_row;         src_col = emit_col;         end
            TR_HFLIP: begin    src_row = emit_row;         src_col = w - 1 - emit_col; end
            TR_VFLIP: begin    src_row = h - 1 - emit_row; src_col = emit_col;         end
            TR_TRANSPOSE: begin src_row = emit_col;        src_col = emit_row;         end
            TR_ROT90: begin    src_row = emit_col;         src_col = w - 1 - emit_row; end
            TR_ROT180: begin   src_row = h - 1 - emit_row; src_col = w - 1 - emit_col; end
            TR_ROT270: begin   src_row = h - 1 - emit_col; src_col = emit_row;         end
            default: begin     src_row = h - 1 - emit_col; src_col = w - 1 - emit_row; end
        endcase
        res.pixel_out = pixel_store[src_row * MAX_W + src_col];
        res.out_col = 8'(emit_col);
        res.out_row = 8'(emit_row);
        res.last = (emit_col + 1 == ow) && (emit_row + 1 == oh);
        expected_pixels.push_back(res);
        if (emit_col + 1 < ow) begin
            emit_col++;
        end else begin
            emit_col = 0;
            emit_row = (emit_row + 1 < oh) ? emit_row + 1 : 0;
        end
    endtask

    // Sends one item, with random idle cycles ahead of it unless no_idle is set, and predicts it once accepted.
    task automatic send_item(input logic mode, input logic [7:0] pixel);
        in_item_t item;
        item.mode = mode;
        item.pixel_in = pixel;
        if (!no_idle) begin
            while ($urandom_range(99) < 24) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_data <= item;
        do @(posedge aclk); while (!s_ready);
        predict_item(item);
        items_sent++;
    endtask

    task automatic load_frame();
        int n;
        n = frame_pixels();
        repeat (n) send_item(MODE_LOAD, 8'($urandom_range(255)));
    endtask

    task automatic fetch_pixels(input int count);
        repeat (count) send_item(MODE_FETCH, 8'($urandom_range(255)));
    endtask

    // Stops the input stream and waits until all results are in and the block has settled.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Writes one register while the block is idle and updates the predictor.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [8:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_TRANSFORM: begin
                cfg_transform = value[2:0];
                restart_positions();
            end
            CFG_IN_WIDTH: begin
                cfg_width = value;
                restart_positions();
            end
            CFG_IN_HEIGHT: begin
                cfg_height = value;
                restart_positions();
            end
            default: begin
            end
        endcase
    endtask

    // Fetches right after reset and after a single load must report a missing frame.
    task automatic test_fetch_before_frame();
        fetch_pixels(2);
        send_item(MODE_LOAD, 8'd0);
        fetch_pixels(1);
    endtask

    // A small non-square frame under rotation, with extreme pixels and a wrapped fetch.
    task automatic test_rotated_frame();
        write_register(CFG_TRANSFORM, {6'd0, TR_ROT90});
        write_register(CFG_IN_WIDTH, 9'd3);
        write_register(CFG_IN_HEIGHT, 9'd2);
        send_item(MODE_LOAD, 8'd0);
        send_item(MODE_LOAD, 8'd255);
        repeat (4) send_item(MODE_LOAD, 8'($urandom_range(255)));
        fetch_pixels(7);
    endtask

    // A load at the origin invalidates the frame; a write to the unused index does not.
    task automatic test_restarted_load();
        send_item(MODE_LOAD, 8'($urandom_range(255)));
        fetch_pixels(1);
        repeat (5) send_item(MODE_LOAD, 8'($urandom_range(255)));
        write_register(CFG_UNUSED, 9'($urandom_range(511)));
        fetch_pixels(2);
    endtask

    // Largest and out-of-range sizes, each loaded once and fetched with a wrap;
    // the first frame runs without idling on either side.
    task automatic test_size_extremes();
        logic [8:0] widths [3];
        logic [8:0] heights [3];
        widths = '{9'd511, 9'd1, 9'd0};
        heights = '{9'd0, 9'd256, 9'd0};
        for (int i = 0; i < 3; i++) begin
            write_register(CFG_TRANSFORM, 9'($urandom_range(7)));
            write_register(CFG_IN_WIDTH, widths[i]);
            write_register(CFG_IN_HEIGHT, heights[i]);
            no_idle <= (i == 0);
            load_frame();
            fetch_pixels(frame_pixels() + 1);
        end
        no_idle <= 1'b0;
    endtask

    // Mostly whole frames loaded and fetched under random settings, the rest random items.
    task automatic test_random_frames();
        int start_count, n;
        start_count = items_sent;
        while (items_sent - start_count < RANDOM_ITEMS) begin
            if ($urandom_range(9) < 7) begin
                write_register(CFG_TRANSFORM, 9'($urandom_range(7)));
                if ($urandom_range(1)) write_register(CFG_IN_WIDTH, 9'($urandom_range(9)));
                if ($urandom_range(1)) write_register(CFG_IN_HEIGHT, 9'($urandom_range(9)));
            end
            if ($urandom_range(9) == 0) write_register(CFG_UNUSED, 9'($urandom_range(511)));
            n = frame_pixels();
            if ($urandom_range(9) < 7) begin
                load_frame();
                fetch_pixels($urandom_range(1, 2 * n + 1));
            end else begin
                repeat ($urandom_range(1, 2 * n + 2))
                    send_item(1'($urandom_range(1)), 8'($urandom_range(255)));
            end
        end
    endtask

    // Result side stalls at random, except during the stretch without idling.
    always @(posedge aclk) begin
        m_ready <= no_idle || ($urandom_range(99) >= 24);
    end

    // Each result is compared with the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_pixels.size() == 0) begin
                $error("unexpected result: pixel_out %0d out_col %0d out_row %0d",
                       m_data.pixel_out, m_data.out_col, m_data.out_row);
                mismatch_count++;
            end else begin
                want_item = expected_pixels.pop_front();
                if (m_data.pixel_out !== want_item.pixel_out) begin
                    $error("pixel_out: expected %0d, actual %0d",
                           want_item.pixel_out, m_data.pixel_out);
                    mismatch_count++;
                end
                if (m_data.out_col !== want_item.out_col) begin
                    $error("out_col: expected %0d, actual %0d", want_item.out_col, m_data.out_col);
                    mismatch_count++;
                end
                if (m_data.out_row !== want_item.out_row) begin
                    $error("out_row: expected %0d, actual %0d", want_item.out_row, m_data.out_row);
                    mismatch_count++;
                end
                if (m_data.last !== want_item.last) begin
                    $error("last: expected %0d, actual %0d", want_item.last, m_data.last);
                    mismatch_count++;
                end
                if (m_data.status !== want_item.status) begin
                    $error("status: expected %0d, actual %0d", want_item.status, m_data.status);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: ends the run when no transfer happens for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Reset, the test sequence and the final verdict.
    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_TRANSFORM;
        cfg_data = '0;
        no_idle = 1'b0;
        items_sent = 0;
        cfg_transform = TR_IDENTITY;
        cfg_width = IN_WIDTH_RESET;
        cfg_height = IN_HEIGHT_RESET;
        restart_positions();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_fetch_before_frame();
        test_rotated_frame();
        test_restarted_load();
        test_size_extremes();
        test_random_frames();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+src
src/dihr_pkg.sv
src/dihr_ram.sv
src/dihr_ctrl.sv
src/image_dihedral_reorganizer_unit.sv
src/dihr_checker.sv
sim/image_dihedral_reorganizer_unit_tb.sv
